>>> sv/bsl_pkg.sv
// bsl_pkg: field widths, operation and status codes, and the controller/datapath
// command and status structs of the bounded sequential list.
// No dependencies.
package bsl_pkg;

  // item field widths
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int INDEX_W  = 4;
  localparam int FILL_W   = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [OP_W-1:0] OP_COUNT      = 3'd6;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // what an accepted item turns into after the checks
  typedef enum logic [2:0] {
    K_ERR,
    K_INS,
    K_DEL,
    K_CNT,
    K_SRCH
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic up_step;
    logic place;
    logic dn_step;
    logic drop;
    logic cnt_step;
    logic probe;
    logic decide;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  up_more;
    logic  asc_more;
    logic  pend;
    logic  range_live;
    logic  hit;
    logic  out_free;
  } stat_t;

endpackage

>>> sv/bsl_req_if.sv
// bsl_req_if: request channel of the bounded sequential list, valid/ready handshake.
// Depends on bsl_pkg for the field widths.
interface bsl_req_if;
  logic                        valid;
  logic                        ready;
  logic [bsl_pkg::OP_W-1:0]    op;
  logic [bsl_pkg::VALUE_W-1:0] value;
  logic [bsl_pkg::POS_W-1:0]   position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink (input valid, input op, input value, input position, output ready);
endinterface

>>> sv/bsl_rsp_if.sv
// bsl_rsp_if: result channel of the bounded sequential list, valid/ready handshake.
// Depends on bsl_pkg for the field widths.
interface bsl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bsl_pkg::STATUS_W-1:0] status;
  logic [bsl_pkg::COUNT_W-1:0]  match_count;
  logic [bsl_pkg::INDEX_W-1:0]  found_index;
  logic [bsl_pkg::FILL_W-1:0]   fill_level;

  modport source (output valid, output status, output match_count, output found_index,
                  output fill_level, input ready);
  modport sink (input valid, input status, input match_count, input found_index,
                input fill_level, output ready);
endinterface

>>> sv/bsl_ram.sv
// bsl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/bsl_ctrl.sv
// bsl_ctrl: state machine that sequences one list item at a time.
// Depends on bsl_pkg for the command and status structs.
module bsl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bsl_pkg::stat_t stat,
  output bsl_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INS    = 7'b0000010,
    S_DEL    = 7'b0000100,
    S_CNT    = 7'b0001000,
    S_PROBE  = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          case (stat.kind)
            bsl_pkg::K_INS:  state_next = S_INS;
            bsl_pkg::K_DEL:  state_next = S_DEL;
            bsl_pkg::K_CNT:  state_next = S_CNT;
            bsl_pkg::K_SRCH: state_next = S_PROBE;
            default:         state_next = S_DONE;
          endcase
        end
      end
      // move entries up one place, then write the new word
      S_INS: begin
        if (stat.up_more || stat.pend) begin
          cmd.up_step = 1'b1;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_DONE;
        end
      end
      // move entries down one place, then shrink
      S_DEL: begin
        if (stat.asc_more || stat.pend) begin
          cmd.dn_step = 1'b1;
        end else begin
          cmd.drop   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_CNT: begin
        if (stat.asc_more || stat.pend) begin
          cmd.cnt_step = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      // one binary search step takes a read and a compare
      S_PROBE: begin
        if (stat.range_live) begin
          cmd.probe  = 1'b1;
          state_next = S_DECIDE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.hit ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/bsl_dpath.sv
// bsl_dpath: entry storage, fill count, walk index, search bounds and result register.
// Depends on bsl_pkg, bsl_rsp_if and bsl_ram.
module bsl_dpath #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bsl_pkg::OP_W-1:0]    op,
  input  logic [bsl_pkg::VALUE_W-1:0] value,
  input  logic [bsl_pkg::POS_W-1:0]   position,
  input  bsl_pkg::cmd_t               cmd,
  output bsl_pkg::stat_t              stat,
  bsl_rsp_if.source                   rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > bsl_pkg::POS_W) ? CW : bsl_pkg::POS_W;
  localparam int FW = (AW > bsl_pkg::INDEX_W) ? AW : bsl_pkg::INDEX_W;
  localparam int XV = (WORD_WIDTH > bsl_pkg::VALUE_W) ? WORD_WIDTH : bsl_pkg::VALUE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // list state and per-item working registers
  logic [CW-1:0]                fill;
  logic [WORD_WIDTH-1:0]        word;
  logic [CW-1:0]                pos;
  logic [CW-1:0]                idx;
  logic [AW-1:0]                wa;
  logic                         pend;
  logic [CW-1:0]                lo;
  logic [CW-1:0]                hx;
  logic [AW-1:0]                mid;
  logic [CW-1:0]                cnt;
  logic [AW-1:0]                found;
  logic [bsl_pkg::STATUS_W-1:0] rstat;

  // result register
  logic                         ovalid;
  logic [bsl_pkg::STATUS_W-1:0] ostatus;
  logic [bsl_pkg::COUNT_W-1:0]  ocount;
  logic [bsl_pkg::INDEX_W-1:0]  ofound;
  logic [bsl_pkg::FILL_W-1:0]   ofill;

  // decode of the incoming item
  bsl_pkg::kind_t               kind_d;
  logic [bsl_pkg::STATUS_W-1:0] stat_d;
  logic [CW-1:0]                ipos_d;
  logic [XW-1:0]                posx;
  logic [XW-1:0]                fillx;
  logic [XW-1:0]                cntx;
  logic [FW-1:0]                foundx;
  logic [XV-1:0]                valx;
  logic                         fempty;
  logic                         ffull;

  // ram and walk signals
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;
  logic [CW-1:0]         idx_dec;
  logic [CW-1:0]         idx_inc;
  logic [CW-1:0]         span;
  logic [CW-1:0]         mid_full;
  logic                  up_more;
  logic                  asc_more;
  logic                  out_free;

  assign posx   = XW'(position);
  assign fillx  = XW'(fill);
  assign cntx   = XW'(cnt);
  assign foundx = FW'(found);
  assign valx   = XV'(value);
  assign fempty = (fill == '0);
  assign ffull  = (fill == DEPTH_C);

  // checks and start position per operation
  always_comb begin
    kind_d = bsl_pkg::K_ERR;
    stat_d = bsl_pkg::ST_OK;
    ipos_d = '0;
    case (op)
      bsl_pkg::OP_PUSH_BACK: begin
        if (ffull) begin
          stat_d = bsl_pkg::ST_FULL;
        end else begin
          kind_d = bsl_pkg::K_INS;
          ipos_d = fill;
        end
      end
      bsl_pkg::OP_PUSH_FRONT: begin
        if (ffull) begin
          stat_d = bsl_pkg::ST_FULL;
        end else begin
          kind_d = bsl_pkg::K_INS;
        end
      end
      bsl_pkg::OP_POP_BACK: begin
        if (fempty) begin
          stat_d = bsl_pkg::ST_EMPTY;
        end else begin
          kind_d = bsl_pkg::K_DEL;
          ipos_d = fill - 1'b1;
        end
      end
      bsl_pkg::OP_POP_FRONT: begin
        if (fempty) begin
          stat_d = bsl_pkg::ST_EMPTY;
        end else begin
          kind_d = bsl_pkg::K_DEL;
        end
      end
      bsl_pkg::OP_INSERT: begin
        if (posx > fillx) begin
          stat_d = bsl_pkg::ST_BADPOS;
        end else if (ffull) begin
          stat_d = bsl_pkg::ST_FULL;
        end else begin
          kind_d = bsl_pkg::K_INS;
          ipos_d = posx[CW-1:0];
        end
      end
      bsl_pkg::OP_ERASE: begin
        if (fempty) begin
          stat_d = bsl_pkg::ST_EMPTY;
        end else if (posx >= fillx) begin
          stat_d = bsl_pkg::ST_BADPOS;
        end else begin
          kind_d = bsl_pkg::K_DEL;
          ipos_d = posx[CW-1:0];
        end
      end
      bsl_pkg::OP_COUNT: begin
        kind_d = bsl_pkg::K_CNT;
      end
      bsl_pkg::OP_SEARCH: begin
        kind_d = bsl_pkg::K_SRCH;
        stat_d = bsl_pkg::ST_NOTFOUND;
      end
      default: begin
        kind_d = bsl_pkg::K_ERR;
      end
    endcase
  end

  // walk and search arithmetic
  assign idx_dec  = idx - 1'b1;
  assign idx_inc  = idx + 1'b1;
  assign up_more  = (idx > pos);
  assign asc_more = (idx < fill);
  assign span     = hx - lo - 1'b1;
  assign mid_full = lo + (span >> 1);
  assign out_free = !ovalid || rsp.ready;

  // ram port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wa;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    if (cmd.up_step) begin
      rd_en   = up_more;
      rd_addr = idx_dec[AW-1:0];
      wr_en   = pend;
    end
    if (cmd.dn_step) begin
      rd_en = asc_more;
      wr_en = pend;
    end
    if (cmd.cnt_step) begin
      rd_en = asc_more;
    end
    if (cmd.place) begin
      wr_en   = 1'b1;
      wr_addr = pos[AW-1:0];
      wr_data = word;
    end
    if (cmd.probe) begin
      rd_en   = 1'b1;
      rd_addr = mid_full[AW-1:0];
    end
  end

  bsl_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // fill count, read-pending flag and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      pend   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (cmd.up_step) begin
        pend <= up_more;
      end else if (cmd.dn_step || cmd.cnt_step) begin
        pend <= asc_more;
      end else begin
        pend <= 1'b0;
      end
      if (cmd.place) begin
        fill <= fill + 1'b1;
      end else if (cmd.drop) begin
        fill <= fill - 1'b1;
      end
      if (cmd.emit) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word  <= valx[WORD_WIDTH-1:0];
      pos   <= ipos_d;
      lo    <= '0;
      hx    <= fill;
      cnt   <= '0;
      found <= '0;
      rstat <= stat_d;
      case (kind_d)
        bsl_pkg::K_INS: idx <= fill;
        bsl_pkg::K_DEL: idx <= ipos_d + 1'b1;
        default:        idx <= '0;
      endcase
    end
    // descending walk: read below, write one place up
    if (cmd.up_step && up_more) begin
      idx <= idx_dec;
      wa  <= idx[AW-1:0];
    end
    // ascending walk: read above, write one place down
    if ((cmd.dn_step || cmd.cnt_step) && asc_more) begin
      idx <= idx_inc;
      wa  <= idx_dec[AW-1:0];
    end
    if (cmd.cnt_step && pend && (rd_data == word)) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.probe) begin
      mid <= mid_full[AW-1:0];
    end
    // narrow the search range
    if (cmd.decide) begin
      if (rd_data == word) begin
        found <= mid;
        rstat <= bsl_pkg::ST_OK;
      end else if (rd_data > word) begin
        hx <= CW'(mid);
      end else begin
        lo <= CW'(mid) + 1'b1;
      end
    end
    if (cmd.emit) begin
      ostatus <= rstat;
      ocount  <= cntx[bsl_pkg::COUNT_W-1:0];
      ofound  <= foundx[bsl_pkg::INDEX_W-1:0];
      ofill   <= fillx[bsl_pkg::FILL_W-1:0];
    end
  end

  // status to the controller
  assign stat.kind       = kind_d;
  assign stat.up_more    = up_more;
  assign stat.asc_more   = asc_more;
  assign stat.pend       = pend;
  assign stat.range_live = (lo < hx);
  assign stat.hit        = (rd_data == word);
  assign stat.out_free   = out_free;

  assign rsp.valid       = ovalid;
  assign rsp.status      = ostatus;
  assign rsp.match_count = ocount;
  assign rsp.found_index = ofound;
  assign rsp.fill_level  = ofill;

  // fill never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_C)
    else $error("fill count above capacity");

  // a word is placed only when there is room
  a_place_room: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> (fill < DEPTH_C))
    else $error("place into a full list");

  // an entry is dropped only from a non-empty list
  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> (fill != '0))
    else $error("drop from an empty list");

  // a waiting result is never overwritten
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!ovalid || rsp.ready))
    else $error("result overwritten before it was taken");

  // a probe always lands inside the live range
  a_probe_live: assert property (@(posedge clk) disable iff (rst)
    cmd.probe |-> (lo < hx))
    else $error("search probe outside the range");

endmodule

>>> sv/bounded_sequential_list.sv
// Items are handled one at a time: a rejected item goes straight to its result, an insert
// or erase moves the entries between its position and the fill, a count reads every
// entry and a search probes the ascending entries by binary search. The next item is
// taken the cycle after the result is loaded; a result not yet taken holds off the load.
// Reset (synchronous) empties the list; the entry RAM is not cleared.
module bounded_sequential_list #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  bsl_req_if.sink   req,
  bsl_rsp_if.source rsp
);

  bsl_pkg::cmd_t  cmd;
  bsl_pkg::stat_t stat;

  // sequencer
  bsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  bsl_dpath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .op       (req.op),
    .value    (req.value),
    .position (req.position),
    .cmd      (cmd),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

>>> dv/bsl_list_checker.sv
// bsl_list_checker: watches the request and result channels of the bounded sequential
// list, keeps its own copy of the list and compares every result with the prediction.
// Depends on bsl_pkg, bsl_req_if and bsl_rsp_if.
module bsl_list_checker #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  bsl_req_if   req,
  bsl_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [bsl_pkg::STATUS_W-1:0] status;
    logic [bsl_pkg::COUNT_W-1:0]  match_count;
    logic [bsl_pkg::INDEX_W-1:0]  found_index;
    logic [bsl_pkg::FILL_W-1:0]   fill_level;
  } list_result_t;

  typedef struct packed {
    logic [bsl_pkg::OP_W-1:0] op;
    list_result_t             result;
  } list_expect_t;

  // shadow copy of the list
  logic [WORD_WIDTH-1:0] list_mem [DEPTH];
  int                    list_fill;

  list_expect_t result_q [$];
  int           error_tally;

  assign mismatches = error_tally;

  // apply one request to the shadow list and work out its result
  task automatic apply_request(input logic [bsl_pkg::OP_W-1:0] op,
                               input logic [bsl_pkg::VALUE_W-1:0] value,
                               input logic [bsl_pkg::POS_W-1:0] position,
                               output list_result_t res);
    logic [WORD_WIDTH-1:0] word;
    int                    pos;
    int                    i;
    int                    lo;
    int                    hi;
    int                    mid;
    int                    hits;
    bit                    done;
    word = WORD_WIDTH'(value);
    pos  = int'(position);
    hits = 0;
    res  = '0;
    res.status = bsl_pkg::ST_OK;
    case (op)
      bsl_pkg::OP_PUSH_BACK: begin
        if (list_fill >= DEPTH) begin
          res.status = bsl_pkg::ST_FULL;
        end else begin
          list_mem[list_fill] = word;
          list_fill++;
        end
      end
      bsl_pkg::OP_PUSH_FRONT: begin
        if (list_fill >= DEPTH) begin
          res.status = bsl_pkg::ST_FULL;
        end else begin
          for (i = list_fill; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = word;
          list_fill++;
        end
      end
      bsl_pkg::OP_POP_BACK: begin
        if (list_fill == 0) res.status = bsl_pkg::ST_EMPTY;
        else list_fill--;
      end
      bsl_pkg::OP_POP_FRONT: begin
        if (list_fill == 0) begin
          res.status = bsl_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
          list_fill--;
        end
      end
      bsl_pkg::OP_INSERT: begin
        // position check comes ahead of the full check
        if (pos > list_fill) begin
          res.status = bsl_pkg::ST_BADPOS;
        end else if (list_fill >= DEPTH) begin
          res.status = bsl_pkg::ST_FULL;
        end else begin
          for (i = list_fill; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = word;
          list_fill++;
        end
      end
      bsl_pkg::OP_ERASE: begin
        if (list_fill == 0) begin
          res.status = bsl_pkg::ST_EMPTY;
        end else if (pos >= list_fill) begin
          res.status = bsl_pkg::ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
          list_fill--;
        end
      end
      bsl_pkg::OP_COUNT: begin
        for (i = 0; i < list_fill; i++) if (list_mem[i] == word) hits++;
        res.match_count = hits[bsl_pkg::COUNT_W-1:0];
      end
      default: begin
        // inclusive-bounds binary search over unsigned ascending entries
        res.status = bsl_pkg::ST_NOTFOUND;
        lo   = 0;
        hi   = list_fill - 1;
        done = 1'b0;
        while (!done && lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (list_mem[mid] == word) begin
            res.status      = bsl_pkg::ST_OK;
            res.found_index = mid[bsl_pkg::INDEX_W-1:0];
            done            = 1'b1;
          end else if (list_mem[mid] > word) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
    endcase
    res.fill_level = list_fill[bsl_pkg::FILL_W-1:0];
  endtask

  // results are checked ahead of new requests in the same cycle
  always @(posedge clk) begin : watch
    list_expect_t want;
    list_result_t got;
    list_result_t pred;
    if (rst) begin
      list_fill = 0;
      foreach (list_mem[k]) list_mem[k] = '0;
      result_q.delete();
      error_tally = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status      = rsp.status;
        got.match_count = rsp.match_count;
        got.found_index = rsp.found_index;
        got.fill_level  = rsp.fill_level;
        if (result_q.size() == 0) begin
          if (error_tally < 10)
            $display("%0t: unexpected result: status %0d count %0d idx %0d fill %0d",
                     $realtime, got.status, got.match_count, got.found_index,
                     got.fill_level);
          error_tally++;
        end else begin
          want = result_q.pop_front();
          if (got.status != want.result.status ||
              got.match_count != want.result.match_count ||
              got.found_index != want.result.found_index ||
              got.fill_level != want.result.fill_level) begin
            if (error_tally < 10) begin
              $write("%0t: mismatch op %0d: expected status %0d count %0d idx %0d fill %0d,",
                     $realtime, want.op, want.result.status, want.result.match_count,
                     want.result.found_index, want.result.fill_level);
              $display(" got status %0d count %0d idx %0d fill %0d", got.status,
                       got.match_count, got.found_index, got.fill_level);
            end
            error_tally++;
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.op, req.value, req.position, pred);
        want.op     = req.op;
        want.result = pred;
        result_q.push_back(want);
      end
    end
    outstanding <= result_q.size();
  end

endmodule

>>> dv/tb.sv
// tb: top of the bounded sequential list testbench; drives requests and result
// backpressure, instantiates the block and the checker and prints the verdict.
// Depends on bsl_pkg, bsl_req_if, bsl_rsp_if, bsl_list_checker and bounded_sequential_list.
module tb;

  localparam int DEPTH        = 16;
  localparam int WORD_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 750;
  localparam int LONG_HOLD    = 250;
  localparam int SETTLE       = 40;
  localparam int OP_BITS      = bsl_pkg::OP_W;
  localparam int POS_BITS     = bsl_pkg::POS_W;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_ANY
  } mix_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   sent_total;

  logic [bsl_pkg::OP_W-1:0] grow_ops   [3] = '{bsl_pkg::OP_PUSH_BACK, bsl_pkg::OP_PUSH_FRONT,
                                               bsl_pkg::OP_INSERT};
  logic [bsl_pkg::OP_W-1:0] shrink_ops [3] = '{bsl_pkg::OP_POP_BACK, bsl_pkg::OP_POP_FRONT,
                                               bsl_pkg::OP_ERASE};

  bsl_req_if req_ch();
  bsl_rsp_if rsp_ch();

  bounded_sequential_list #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bsl_list_checker #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) list_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one item after a random gap and wait for it to be taken
  task automatic send_item(input logic [bsl_pkg::OP_W-1:0] op,
                           input logic [bsl_pkg::VALUE_W-1:0] value,
                           input logic [bsl_pkg::POS_W-1:0] position);
    int gap;
    gap = ((sent_total / 64) % 5 == 2) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.value    <= value;
    req_ch.position <= position;
    do @(posedge clk); while (!req_ch.ready);
    sent_total++;
  endtask

  // stop offering until every expected result has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // empty the list, refill it in ascending order, then search and count
  task automatic run_sorted_pass();
    logic [bsl_pkg::VALUE_W-1:0] keys [DEPTH];
    logic [bsl_pkg::VALUE_W-1:0] v;
    logic [bsl_pkg::VALUE_W-1:0] target;
    int                          n;
    repeat (DEPTH + 1)
      send_item($urandom_range(0, 1) ? bsl_pkg::OP_POP_FRONT : bsl_pkg::OP_POP_BACK,
                $urandom(), POS_BITS'($urandom_range(0, 31)));
    n = $urandom_range(1, DEPTH);
    v = $urandom_range(0, 32'h0FFF_FFFF);
    for (int i = 0; i < n; i++) begin
      keys[i] = v;
      send_item(bsl_pkg::OP_PUSH_BACK, v, POS_BITS'($urandom_range(0, 31)));
      // some repeats so that counts above one show up
      if ($urandom_range(0, 3) != 0) v = v + $urandom_range(1, 32'h0FFF_FFFF);
    end
    repeat (8) begin
      target = ($urandom_range(0, 3) != 0) ? keys[$urandom_range(0, n - 1)] : $urandom();
      send_item(($urandom_range(0, 3) == 0) ? bsl_pkg::OP_COUNT : bsl_pkg::OP_SEARCH,
                target, POS_BITS'($urandom_range(0, 31)));
    end
  endtask

  // random segment biased toward growing, shrinking or neither
  task automatic run_mixed_segment(input mix_t mix, input int n);
    logic [bsl_pkg::VALUE_W-1:0] pool [6];
    logic [bsl_pkg::OP_W-1:0]    op;
    logic [bsl_pkg::VALUE_W-1:0] value;
    logic [bsl_pkg::POS_W-1:0]   position;
    int                          r;
    foreach (pool[k]) pool[k] = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 3);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (mix == MIX_GROW && r < 70) op = grow_ops[$urandom_range(0, 2)];
      else if (mix == MIX_SHRINK && r < 70) op = shrink_ops[$urandom_range(0, 2)];
      else op = OP_BITS'($urandom_range(bsl_pkg::OP_PUSH_BACK, bsl_pkg::OP_SEARCH));
      value    = ($urandom_range(0, 4) == 0) ? $urandom() : pool[$urandom_range(0, 5)];
      position = ($urandom_range(0, 7) == 0) ? POS_BITS'($urandom_range(0, 31))
                                             : POS_BITS'($urandom_range(0, DEPTH));
      send_item(op, value, position);
    end
  endtask

  // request side: directed items, random items, then the verdict
  initial begin : request_source
    int  stop_at;
    bit  paused;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= bsl_pkg::OP_PUSH_BACK;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    sent_total = 0;
    paused     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list corner cases
    send_item(bsl_pkg::OP_POP_BACK, 32'h0, 5'd0);
    send_item(bsl_pkg::OP_POP_FRONT, 32'hFFFF_FFFF, 5'd31);
    send_item(bsl_pkg::OP_ERASE, 32'h0, 5'd31);
    send_item(bsl_pkg::OP_SEARCH, 32'h0, 5'd0);
    send_item(bsl_pkg::OP_COUNT, 32'h0, 5'd0);
    send_item(bsl_pkg::OP_INSERT, 32'h1234_5678, 5'd1);

    // fill to capacity in ascending order
    for (int i = 1; i < DEPTH - 1; i++)
      send_item(bsl_pkg::OP_PUSH_BACK, i * 32'h1111_1111, 5'd0);
    send_item(bsl_pkg::OP_PUSH_FRONT, 32'h0, 5'd0);
    send_item(bsl_pkg::OP_INSERT, 32'hFFFF_FFFF, POS_BITS'(DEPTH - 1));

    // full list corner cases, searches at both ends, position at and past the fill
    send_item(bsl_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5, 5'd0);
    send_item(bsl_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 5'd0);
    send_item(bsl_pkg::OP_INSERT, 32'h1, POS_BITS'(DEPTH));
    send_item(bsl_pkg::OP_INSERT, 32'h1, POS_BITS'(DEPTH + 1));
    send_item(bsl_pkg::OP_SEARCH, 32'hFFFF_FFFF, 5'd0);
    send_item(bsl_pkg::OP_SEARCH, 32'h0, 5'd0);
    send_item(bsl_pkg::OP_SEARCH, 32'h1111_1110, 5'd0);
    send_item(bsl_pkg::OP_COUNT, 32'h1111_1111, 5'd0);
    send_item(bsl_pkg::OP_ERASE, 32'h0, POS_BITS'(DEPTH));
    send_item(bsl_pkg::OP_ERASE, 32'h0, 5'd0);
    send_item(bsl_pkg::OP_POP_BACK, 32'h0, 5'd0);
    wait_drained();

    // random part
    stop_at = sent_total + RANDOM_ITEMS;
    while (sent_total < stop_at) begin
      if ($urandom_range(0, 9) < 3) run_sorted_pass();
      else run_mixed_segment(mix_t'($urandom_range(MIX_GROW, MIX_ANY)), $urandom_range(20, 60));
      if (!paused && sent_total > stop_at - RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random stalls, quiet stretches and two long hold-offs
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 150 || taken == 520) gap = LONG_HOLD;
      else if ((taken / 48) % 5 == 3) gap = 0;
      else gap = $urandom_range(0, 9);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      taken++;
    end
  end

endmodule
